// File: sv/peak_track_min_cost_assert.svh
// Assertion macros for the peak tracker, clocked on clk_i and held off during reset.
`ifndef PEAK_TRACK_MIN_COST_ASSERT_SVH
`define PEAK_TRACK_MIN_COST_ASSERT_SVH

// Same-cycle implication.
`define PTMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("peak tracker check failed");

// Next-cycle implication.
`define PTMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("peak tracker check failed");

`endif

// File: sv/ptmc_pkg.sv
// Shared types, constants and control bundles of the peak tracker.
package ptmc_pkg;

  localparam int unsigned MAX_CAND_DEF  = 8;
  localparam int unsigned COST_BITS_DEF = 48;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned D2_W   = 2 * POS_W;
  localparam int unsigned ROOT_W = 24;
  localparam int unsigned QUOT_W = 48;
  localparam int unsigned PROD_W = D2_W + ROOT_W;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned W_W    = PROD_W - FRAC_W;

  // APB register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0]  REG_WEIGHT = 1'b0;

  // Frame phase codes
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_LATER  = 2'd2;

  // Output source select
  localparam logic OUT_SEL_FFC = 1'b0;
  localparam logic OUT_SEL_CUR = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [MAG_W-1:0] magnitude;
    logic             frame_end;
    logic             sequence_end;
  } in_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] chosen_position;
    logic             run_last;
    logic             sequence_last;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic close;
    logic start_entry;
    logic dir_b;
    logic dist_en;
    logic mul;
    logic acc;
    logic j_inc;
    logic commit;
    logic scan_init;
    logic scan_step;
    logic load_out;
    logic out_sel;
    logic end_frame;
  } cmd_t;

  typedef struct packed {
    logic       pos_zero;
    logic       closed;
    logic       full;
    logic [1:0] phase;
    logic       prev_empty;
    logic       j_last;
    logic       weight;
    logic       den_zero;
    logic       root_done;
    logic       frm_end;
    logic       seq_end;
    logic       out_free;
  } sts_t;

endpackage

// File: sv/ptmc_root.sv
// Iterative unit: floor(sqrt(floor(num * 2^32 / den))), one bit per cycle.
module ptmc_root (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ptmc_pkg::MAG_W-1:0]   num_i,
  input  logic [ptmc_pkg::MAG_W-1:0]   den_i,
  output logic                         done_o,
  output logic [ptmc_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned QW = ptmc_pkg::QUOT_W;

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_e;

  rstate_e                      state_q;
  logic [5:0]                   cnt_q;
  logic                         done_q;
  logic [ptmc_pkg::MAG_W-1:0]   num_q;
  logic [ptmc_pkg::MAG_W-1:0]   den_q;
  logic [ptmc_pkg::MAG_W-1:0]   rem_q;
  logic [QW-1:0]                v_q;
  logic [QW-1:0]                r_q;
  logic [QW-1:0]                bit_q;

  logic [ptmc_pkg::MAG_W:0]     r2;
  logic                         qbit;
  logic [QW-1:0]                trial;
  logic                         fits;

  // Restoring divide step
  assign r2   = {rem_q, num_q[ptmc_pkg::MAG_W-1]};
  assign qbit = (r2 >= {1'b0, den_q});

  // Square-root step
  assign trial = r_q + bit_q;
  assign fits  = (v_q >= trial);

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            state_q <= R_DIV;
            cnt_q   <= 6'(QW - 1);
          end
        end
        R_DIV: begin
          if (cnt_q == '0) begin
            state_q <= R_SQRT;
            cnt_q   <= 6'(ptmc_pkg::ROOT_W - 1);
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        R_SQRT: begin
          if (cnt_q == '0) begin
            state_q <= R_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  // Datapath of the unit
  always_ff @(posedge clk_i) begin
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          num_q <= num_i;
          den_q <= den_i;
          rem_q <= '0;
          v_q   <= '0;
        end
      end
      R_DIV: begin
        num_q <= {num_q[ptmc_pkg::MAG_W-2:0], 1'b0};
        rem_q <= qbit ? ptmc_pkg::MAG_W'(r2 - {1'b0, den_q}) : r2[ptmc_pkg::MAG_W-1:0];
        v_q   <= {v_q[QW-2:0], qbit};
        if (cnt_q == '0) begin
          r_q   <= '0;
          bit_q <= QW'(1) << (QW - 2);
        end
      end
      R_SQRT: begin
        if (fits) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign root_o = r_q[ptmc_pkg::ROOT_W-1:0];

endmodule

// File: sv/ptmc_datapath.sv
// Datapath of the peak tracker: candidate banks, cost arithmetic, picks, result register.
module ptmc_datapath #(
  parameter int unsigned MAX_CANDIDATES = ptmc_pkg::MAX_CAND_DEF,
  parameter int unsigned COST_BITS      = ptmc_pkg::COST_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptmc_pkg::cmd_t       cmd_i,
  output ptmc_pkg::sts_t       sts_o,
  input  logic                 weight_i,
  input  ptmc_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ptmc_pkg::out_beat_t  out_data_o
);

  localparam int unsigned N  = MAX_CANDIDATES;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned CB = COST_BITS;
  localparam int unsigned WW = (CB > ptmc_pkg::W_W) ? CB : ptmc_pkg::W_W;
  localparam int unsigned PW = ptmc_pkg::POS_W;
  localparam int unsigned MW = ptmc_pkg::MAG_W;
  localparam logic [CB-1:0] COST_MAX = {CB{1'b1}};

  ptmc_pkg::in_beat_t  itm_q;
  ptmc_pkg::out_beat_t out_q;
  logic                out_valid_q;

  logic [PW-1:0] pos_q  [2][N];
  logic [MW-1:0] mag_q  [2][N];
  logic [CB-1:0] cost_q [2][N];
  logic [CB-1:0] ffc_q  [N];
  logic          bank_q;
  logic [CW-1:0] prev_count_q;
  logic [CW-1:0] cur_count_q;
  logic [1:0]    phase_q;
  logic          closed_q;
  logic [IW-1:0] j_q;

  logic [CB-1:0] best_q;
  logic [ptmc_pkg::D2_W-1:0]   d2_q;
  logic [ptmc_pkg::PROD_W-1:0] prod_q;
  logic [CB-1:0] pick_cost_q;
  logic [PW-1:0] pick_pos_q;
  logic [CB-1:0] scan_cost_q;
  logic [PW-1:0] scan_pos_q;
  logic          scan_valid_q;

  logic          pb;
  logic [IW-1:0] k;
  logic [PW-1:0] ppos;
  logic [MW-1:0] pmag;
  logic [CB-1:0] pcost;
  logic [PW-1:0] dist_abs;
  logic [MW-1:0] num;
  logic [MW-1:0] den;
  logic          den_zero;
  logic          root_done;
  logic [ptmc_pkg::ROOT_W-1:0] root;
  logic [WW-1:0] w;
  logic          w_sat;
  logic [CB-1:0] pc;
  logic [CB:0]   sum;
  logic [CB-1:0] sum_sat;
  logic          out_free;

  // Operands of the current pair
  assign pb       = ~bank_q;
  assign k        = cur_count_q[IW-1:0];
  assign ppos     = pos_q[pb][j_q];
  assign pmag     = mag_q[pb][j_q];
  assign pcost    = cost_q[pb][j_q];
  assign dist_abs = (itm_q.position >= ppos) ? (itm_q.position - ppos)
                                             : (ppos - itm_q.position);
  assign num      = cmd_i.dir_b ? itm_q.magnitude : pmag;
  assign den      = cmd_i.dir_b ? pmag : itm_q.magnitude;
  assign den_zero = (den == '0);

  ptmc_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.dist_en && weight_i && !den_zero),
    .num_i   (num),
    .den_i   (den),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Pair cost with saturation
  assign w     = WW'(prod_q[ptmc_pkg::PROD_W-1:ptmc_pkg::FRAC_W]);
  assign w_sat = ((w >> CB) != '0);
  always_comb begin
    if (!weight_i) begin
      pc = CB'(d2_q);
    end else if (den_zero || w_sat) begin
      pc = COST_MAX;
    end else begin
      pc = w[CB-1:0];
    end
  end
  assign sum     = {1'b0, pc} + {1'b0, pcost};
  assign sum_sat = sum[CB] ? COST_MAX : sum[CB-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  // Frame state and picks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q       <= 1'b0;
      prev_count_q <= '0;
      cur_count_q  <= '0;
      phase_q      <= ptmc_pkg::PHASE_FIRST;
      closed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < N; i++) ffc_q[i] <= COST_MAX;
    end else begin
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.close) closed_q <= 1'b1;
      if (cmd_i.acc && cmd_i.dir_b && (pc < ffc_q[j_q])) ffc_q[j_q] <= pc;
      if (cmd_i.commit) cur_count_q <= cur_count_q + CW'(1);
      if (cmd_i.end_frame) begin
        closed_q    <= 1'b0;
        cur_count_q <= '0;
        if (itm_q.sequence_end) begin
          prev_count_q <= '0;
          phase_q      <= ptmc_pkg::PHASE_FIRST;
          for (int i = 0; i < N; i++) ffc_q[i] <= COST_MAX;
        end else begin
          bank_q       <= ~bank_q;
          prev_count_q <= cur_count_q;
          if (phase_q == ptmc_pkg::PHASE_FIRST) begin
            phase_q <= ptmc_pkg::PHASE_SECOND;
            for (int i = 0; i < N; i++) ffc_q[i] <= COST_MAX;
          end else begin
            phase_q <= ptmc_pkg::PHASE_LATER;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) itm_q <= in_data_i;
    if (cmd_i.start_entry) begin
      best_q <= (phase_q == ptmc_pkg::PHASE_FIRST) ? '0 : COST_MAX;
      j_q    <= '0;
    end
    if (cmd_i.scan_init) begin
      scan_valid_q <= 1'b0;
      scan_pos_q   <= '0;
      j_q          <= '0;
    end
    if (cmd_i.j_inc) j_q <= j_q + IW'(1);
    if (cmd_i.dist_en) d2_q <= ptmc_pkg::D2_W'(dist_abs) * ptmc_pkg::D2_W'(dist_abs);
    if (cmd_i.mul) prod_q <= ptmc_pkg::PROD_W'(d2_q) * ptmc_pkg::PROD_W'(root);
    if (cmd_i.acc && !cmd_i.dir_b && (sum_sat < best_q)) best_q <= sum_sat;
    if (cmd_i.commit) begin
      pos_q[bank_q][k]  <= itm_q.position;
      mag_q[bank_q][k]  <= itm_q.magnitude;
      cost_q[bank_q][k] <= best_q;
      if ((cur_count_q == '0) || (best_q < pick_cost_q)) begin
        pick_cost_q <= best_q;
        pick_pos_q  <= itm_q.position;
      end
    end
    if (cmd_i.scan_step && (!scan_valid_q || (ffc_q[j_q] < scan_cost_q))) begin
      scan_valid_q <= 1'b1;
      scan_cost_q  <= ffc_q[j_q];
      scan_pos_q   <= ppos;
    end
    if (cmd_i.load_out) begin
      if (cmd_i.out_sel == ptmc_pkg::OUT_SEL_FFC) begin
        out_q.chosen_position <= scan_pos_q;
        out_q.run_last        <= 1'b0;
        out_q.sequence_last   <= 1'b0;
      end else begin
        out_q.chosen_position <= (cur_count_q == '0) ? '0 : pick_pos_q;
        out_q.run_last        <= 1'b1;
        out_q.sequence_last   <= itm_q.sequence_end;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.pos_zero   = (itm_q.position == '0);
    sts_o.closed     = closed_q;
    sts_o.full       = (cur_count_q == CW'(N));
    sts_o.phase      = phase_q;
    sts_o.prev_empty = (prev_count_q == '0);
    sts_o.j_last     = ((CW'(j_q) + CW'(1)) == prev_count_q);
    sts_o.weight     = weight_i;
    sts_o.den_zero   = den_zero;
    sts_o.root_done  = root_done;
    sts_o.frm_end    = itm_q.frame_end || itm_q.sequence_end;
    sts_o.seq_end    = itm_q.sequence_end;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/ptmc_ctrl.sv
// Controller of the peak tracker: sequences one beat through cost search and result emission.
module ptmc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ptmc_pkg::sts_t  sts_i,
  output ptmc_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIST, S_ROOT, S_MUL, S_ACC, S_COMMIT,
    S_FRAME, S_SCAN, S_EMIT_FFC, S_EMIT_CUR, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   dir_q, dir_d;

  // Commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    dir_d   = dir_q;
    cmd_o.dir_b   = dir_q;
    cmd_o.out_sel = ptmc_pkg::OUT_SEL_CUR;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.closed && sts_i.pos_zero) begin
          cmd_o.close = 1'b1;
          state_d     = S_FRAME;
        end else if (!sts_i.closed && !sts_i.full) begin
          cmd_o.start_entry = 1'b1;
          dir_d             = 1'b0;
          if (sts_i.phase != ptmc_pkg::PHASE_FIRST && !sts_i.prev_empty) begin
            state_d = S_DIST;
          end else begin
            state_d = S_COMMIT;
          end
        end else begin
          state_d = S_FRAME;
        end
      end
      S_DIST: begin
        cmd_o.dist_en = 1'b1;
        state_d       = (sts_i.weight && !sts_i.den_zero) ? S_ROOT : S_ACC;
      end
      S_ROOT: begin
        if (sts_i.root_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (!dir_q && sts_i.phase == ptmc_pkg::PHASE_SECOND) begin
          dir_d   = 1'b1;
          state_d = S_DIST;
        end else begin
          dir_d = 1'b0;
          if (sts_i.j_last) begin
            state_d = S_COMMIT;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d     = S_DIST;
          end
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_FRAME;
      end
      S_FRAME: begin
        if (!sts_i.frm_end) begin
          state_d = S_IDLE;
        end else begin
          case (sts_i.phase)
            ptmc_pkg::PHASE_FIRST:  state_d = sts_i.seq_end ? S_EMIT_CUR : S_FINISH;
            ptmc_pkg::PHASE_SECOND: begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
            default: state_d = S_EMIT_CUR;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.prev_empty) begin
          state_d = S_EMIT_FFC;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.j_last) begin
            state_d = S_EMIT_FFC;
          end else begin
            cmd_o.j_inc = 1'b1;
          end
        end
      end
      S_EMIT_FFC: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = ptmc_pkg::OUT_SEL_FFC;
          state_d        = S_EMIT_CUR;
        end
      end
      S_EMIT_CUR: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.end_frame = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: sv/peak_track_min_cost.sv
// Top level of the peak tracker: APB register, controller and datapath.
//
//  channel | direction | handshake             | beat
//  in      | sink      | in_valid_i/in_stall_o   | ptmc_pkg::in_beat_t
//  out     | source    | out_valid_o/out_stall_i | ptmc_pkg::out_beat_t
//  cfg     | APB slave | psel/penable/pready     | weight_by_magnitude at 0x0
//
// A beat is taken in idle and the input stalls until it is through; in frames after the
// first each previous candidate adds a distance step, a wait on the shared divide and
// square-root unit (48 + 24 steps), a multiply and an accumulate when weighted (distance
// and accumulate only unweighted or with a zero divisor magnitude), twice in the second
// frame. A second-frame end scans the first-frame candidates, one per cycle. Reset leaves
// it ready. A stalled result blocks the next emission, and no beat is taken meanwhile.
module peak_track_min_cost #(
  parameter int unsigned MAX_CANDIDATES = ptmc_pkg::MAX_CAND_DEF,
  parameter int unsigned COST_BITS      = ptmc_pkg::COST_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ptmc_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ptmc_pkg::out_beat_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptmc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  `include "peak_track_min_cost_assert.svh"

  ptmc_pkg::cmd_t cmd;
  ptmc_pkg::sts_t sts;
  logic           weight_q;
  logic           reg_sel;

  // Configuration register
  assign reg_sel = (paddr[ptmc_pkg::ADDR_W-1:2] == ptmc_pkg::REG_WEIGHT);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 1'b1;
    end else if (psel && penable && pwrite && reg_sel) begin
      weight_q <= pwdata[0];
    end
  end
  assign prdata = reg_sel ? {31'b0, weight_q} : 32'b0;
  assign pready = 1'b1;

  ptmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptmc_datapath #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .COST_BITS      (COST_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .weight_i    (weight_q),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Multiply only after the root unit finished
  `PTMC_ASSERT_IMP(a_mul_after_root, cmd.mul, $past(sts.root_done))
  // Never overwrite a result that waits
  `PTMC_ASSERT_IMP(a_no_overwrite, cmd.load_out, sts.out_free)
  // Busy right after taking a beat
  `PTMC_ASSERT_NXT(a_busy_after_accept, cmd.accept, in_stall_o)

endmodule
